/* sv/tile_background_pixel_unit_top_macros.svh */
// Assertion macros shared by the tile background pixel unit modules.
`ifndef TILE_BACKGROUND_PIXEL_UNIT_TOP_MACROS_SVH
`define TILE_BACKGROUND_PIXEL_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBPU_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBPU_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/tbpu_pkg.sv */
// Shared types and constants of the tile background pixel unit.
package tbpu_pkg;

    // Memory and map sizes are powers of two.
    localparam int DEF_VIDEO_BYTES   = 32768;
    localparam int DEF_PALETTE_BYTES = 512;
    localparam int DEF_MAP_TILES     = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CFG_DATA_W = 8;

    typedef enum logic [2:0] {
        FN_SET_ADDR = 3'd0,
        FN_WORD     = 3'd1,
        FN_LOW      = 3'd2,
        FN_HIGH     = 3'd3,
        FN_PAL      = 3'd4,
        FN_PIXEL    = 3'd5
    } t_func;

    typedef enum logic {
        CFG_MAP_BASE  = 1'b0,
        CFG_STEP_HIGH = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        CMD_VWRITE = 2'd0,
        CMD_PWRITE = 2'd1,
        CMD_PIXEL  = 2'd2
    } t_cmd_op;

    // One queued item for the back end. addr is a video word index or a palette byte address.
    typedef struct packed {
        t_cmd_op     op;
        logic        lane_lo;
        logic        lane_hi;
        logic [15:0] addr;
        logic [15:0] data;
        logic [7:0]  px;
        logic [7:0]  py;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MAP,
        BK_TILE,
        BK_PAL
    } t_back_state;

endpackage

/* sv/tbpu_queue.sv */
// Small command queue between the front end and the back end.
`include "tile_background_pixel_unit_top_macros.svh"

module tbpu_queue #(
    parameter int DEPTH = tbpu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbpu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output tbpu_pkg::t_cmd o_cmd
);
    import tbpu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `TBPU_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, o_full, !i_push, "push into full queue")

endmodule

/* sv/tbpu_front.sv */
// Front end: accepts items, keeps the write addresses and queues memory work.
`include "tile_background_pixel_unit_top_macros.svh"

module tbpu_front #(
    parameter int PALETTE_BYTES = tbpu_pkg::DEF_PALETTE_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2:0]            i_func,
    input  logic [15:0]           i_write_data,
    input  logic [7:0]            i_pixel_x,
    input  logic [7:0]            i_pixel_y,
    input  logic                  i_step_after_high,
    input  tbpu_pkg::t_back_status i_status,
    input  logic                  i_queue_full,
    output logic                  o_busy,
    output logic                  o_push,
    output tbpu_pkg::t_cmd        o_cmd
);
    import tbpu_pkg::*;

    localparam int PB_AW = $clog2(PALETTE_BYTES);

    logic [15:0]      r_word_addr, n_word_addr;
    logic [PB_AW-1:0] r_pal_addr, n_pal_addr;
    logic             accept;

    assign o_busy = i_status.clearing | i_queue_full;
    assign accept = i_start & ~o_busy;

    always_comb begin
        n_word_addr = r_word_addr;
        n_pal_addr  = r_pal_addr;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.addr  = r_word_addr;
        o_cmd.px    = i_pixel_x;
        o_cmd.py    = i_pixel_y;
        if (accept) begin
            case (t_func'(i_func))
                FN_SET_ADDR: begin
                    n_word_addr = i_write_data;
                end
                FN_WORD: begin
                    o_push        = 1'b1;
                    o_cmd.op      = CMD_VWRITE;
                    o_cmd.lane_lo = 1'b1;
                    o_cmd.lane_hi = 1'b1;
                    o_cmd.data    = i_write_data;
                    n_word_addr   = r_word_addr + 1'b1;
                end
                FN_LOW: begin
                    o_push        = 1'b1;
                    o_cmd.op      = CMD_VWRITE;
                    o_cmd.lane_lo = 1'b1;
                    o_cmd.data    = {8'h00, i_write_data[7:0]};
                    if (!i_step_after_high) begin
                        n_word_addr = r_word_addr + 1'b1;
                    end
                end
                FN_HIGH: begin
                    o_push        = 1'b1;
                    o_cmd.op      = CMD_VWRITE;
                    o_cmd.lane_hi = 1'b1;
                    o_cmd.data    = {i_write_data[7:0], 8'h00};
                    if (i_step_after_high) begin
                        n_word_addr = r_word_addr + 1'b1;
                    end
                end
                FN_PAL: begin
                    o_push     = 1'b1;
                    o_cmd.op   = CMD_PWRITE;
                    o_cmd.addr = 16'(r_pal_addr);
                    o_cmd.data = {8'h00, i_write_data[7:0]};
                    n_pal_addr = r_pal_addr + 1'b1;
                end
                FN_PIXEL: begin
                    o_push   = 1'b1;
                    o_cmd.op = CMD_PIXEL;
                end
                default: begin
                    // unused codes: item taken, nothing done
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_addr <= '0;
            r_pal_addr  <= '0;
        end else begin
            r_word_addr <= n_word_addr;
            r_pal_addr  <= n_pal_addr;
        end
    end

    `TBPU_ASSERT_IMP(a_no_push_clear, i_clk, i_rst_n, i_status.clearing, !o_push, "push during clear")

endmodule

/* sv/tbpu_back.sv */
// Back end: video and palette memories, clearing sweep and the pixel lookup sequencer.
`include "tile_background_pixel_unit_top_macros.svh"

module tbpu_back #(
    parameter int VIDEO_BYTES   = tbpu_pkg::DEF_VIDEO_BYTES,
    parameter int PALETTE_BYTES = tbpu_pkg::DEF_PALETTE_BYTES,
    parameter int MAP_TILES     = tbpu_pkg::DEF_MAP_TILES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  tbpu_pkg::t_cmd         i_cmd,
    input  logic [7:0]             i_map_base,
    output logic                   o_pop,
    output tbpu_pkg::t_back_status o_status,
    output logic                   o_strobe,
    output logic [4:0]             o_red,
    output logic [4:0]             o_green,
    output logic [4:0]             o_blue
);
    import tbpu_pkg::*;

    localparam int VIDEO_WORDS = VIDEO_BYTES / 2;
    localparam int PAL_WORDS   = PALETTE_BYTES / 2;
    localparam int VW_AW       = $clog2(VIDEO_WORDS);
    localparam int PW_AW       = $clog2(PAL_WORDS);
    localparam int PB_AW       = $clog2(PALETTE_BYTES);
    localparam int MT_W        = $clog2(MAP_TILES);

    t_back_state      r_state, n_state;
    logic [VW_AW-1:0] r_clr_idx, n_clr_idx;
    logic [2:0]       r_fine_x, n_fine_x;
    logic [2:0]       r_row, n_row;
    logic [2:0]       r_pal, n_pal;
    logic             r_strobe, n_strobe;
    logic [14:0]      r_colour;

    // word-wide memories split into byte lanes
    logic [7:0] r_vid_lo [VIDEO_WORDS];
    logic [7:0] r_vid_hi [VIDEO_WORDS];
    logic [7:0] r_plt_lo [PAL_WORDS];
    logic [7:0] r_plt_hi [PAL_WORDS];

    logic [7:0] r_rd_a_lo, r_rd_a_hi, r_rd_b_lo, r_rd_b_hi;
    logic [7:0] r_cr_lo, r_cr_hi;

    logic             vid_we_lo, vid_we_hi;
    logic [VW_AW-1:0] vid_waddr;
    logic [7:0]       vid_wlo, vid_whi;
    logic             plt_we_lo, plt_we_hi;
    logic [PW_AW-1:0] plt_waddr;
    logic [7:0]       plt_wdata;
    logic [VW_AW-1:0] rd_addr_a, rd_addr_b;
    logic [PW_AW-1:0] cr_addr;
    logic             dispatch;

    logic [MT_W-1:0]  cx, cy;
    logic [15:0]      map_word;
    logic [15:0]      entry;
    logic [15:0]      tw_a, tw_b;
    logic [2:0]       sel;
    logic [3:0]       idx;
    logic [7:0]       pal_word;

    assign o_status.clearing = (r_state == BK_CLEAR);
    assign o_strobe = r_strobe;
    assign o_red    = r_colour[4:0];
    assign o_green  = r_colour[9:5];
    assign o_blue   = r_colour[14:10];

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_fine_x  = r_fine_x;
        n_row     = r_row;
        n_pal     = r_pal;
        n_strobe  = 1'b0;
        o_pop     = 1'b0;
        dispatch  = 1'b0;
        vid_we_lo = 1'b0;
        vid_we_hi = 1'b0;
        vid_waddr = i_cmd.addr[VW_AW-1:0];
        vid_wlo   = i_cmd.data[7:0];
        vid_whi   = i_cmd.data[15:8];
        plt_we_lo = 1'b0;
        plt_we_hi = 1'b0;
        plt_waddr = i_cmd.addr[PB_AW-1:1];
        plt_wdata = i_cmd.data[7:0];
        rd_addr_a = '0;
        rd_addr_b = '0;
        cr_addr   = '0;

        // tilemap word of the requested cell, wrapping within the map and memory
        cx       = MT_W'(i_cmd.px[7:3]);
        cy       = MT_W'(i_cmd.py[7:3]);
        map_word = {i_map_base[7:2], 10'd0} + 16'({cy, cx});

        // tile row words: planes 0/1, then planes 2/3 eight words on
        entry = {r_rd_a_hi, r_rd_a_lo};
        tw_a  = 16'({entry[9:0], 1'b0, r_row});
        tw_b  = 16'({entry[9:0], 1'b1, r_row});

        // bit 7 is the leftmost column
        sel      = ~r_fine_x;
        idx      = {r_rd_b_hi[sel], r_rd_b_lo[sel], r_rd_a_hi[sel], r_rd_a_lo[sel]};
        pal_word = {1'b0, r_pal, idx};

        case (r_state)
            BK_CLEAR: begin
                vid_we_lo = 1'b1;
                vid_we_hi = 1'b1;
                vid_waddr = r_clr_idx;
                vid_wlo   = '0;
                vid_whi   = '0;
                plt_waddr = r_clr_idx[PW_AW-1:0];
                plt_wdata = '0;
                if (r_clr_idx < VW_AW'(PAL_WORDS)) begin
                    plt_we_lo = 1'b1;
                    plt_we_hi = 1'b1;
                end
                if (r_clr_idx == VW_AW'(VIDEO_WORDS - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            BK_IDLE: begin
                dispatch = 1'b1;
            end
            BK_MAP: begin
                rd_addr_a = tw_a[VW_AW-1:0];
                rd_addr_b = tw_b[VW_AW-1:0];
                n_pal     = entry[12:10];
                n_state   = BK_TILE;
            end
            BK_TILE: begin
                cr_addr = pal_word[PW_AW-1:0];
                n_state = BK_PAL;
            end
            BK_PAL: begin
                // colour is ready; the next item is taken in the same cycle
                n_strobe = 1'b1;
                dispatch = 1'b1;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (dispatch) begin
            n_state = BK_IDLE;
            if (i_q_valid) begin
                o_pop = 1'b1;
                case (i_cmd.op)
                    CMD_VWRITE: begin
                        vid_we_lo = i_cmd.lane_lo;
                        vid_we_hi = i_cmd.lane_hi;
                    end
                    CMD_PWRITE: begin
                        plt_we_lo = ~i_cmd.addr[0];
                        plt_we_hi = i_cmd.addr[0];
                    end
                    CMD_PIXEL: begin
                        rd_addr_a = map_word[VW_AW-1:0];
                        n_fine_x  = i_cmd.px[2:0];
                        n_row     = i_cmd.py[2:0];
                        n_state   = BK_MAP;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_idx <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fine_x <= n_fine_x;
        r_row    <= n_row;
        r_pal    <= n_pal;
        if (n_strobe) begin
            r_colour <= {r_cr_hi[6:0], r_cr_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (vid_we_lo) begin
            r_vid_lo[vid_waddr] <= vid_wlo;
        end
        if (vid_we_hi) begin
            r_vid_hi[vid_waddr] <= vid_whi;
        end
        r_rd_a_lo <= r_vid_lo[rd_addr_a];
        r_rd_a_hi <= r_vid_hi[rd_addr_a];
        r_rd_b_lo <= r_vid_lo[rd_addr_b];
        r_rd_b_hi <= r_vid_hi[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (plt_we_lo) begin
            r_plt_lo[plt_waddr] <= plt_wdata;
        end
        if (plt_we_hi) begin
            r_plt_hi[plt_waddr] <= plt_wdata;
        end
        r_cr_lo <= r_plt_lo[cr_addr];
        r_cr_hi <= r_plt_hi[cr_addr];
    end

    `TBPU_ASSERT_NXT(a_pal_strobe, i_clk, i_rst_n, r_state == BK_PAL, r_strobe, "missing strobe")
    `TBPU_ASSERT_NXT(a_map_tile, i_clk, i_rst_n, r_state == BK_MAP, r_state == BK_TILE, "bad seq")
    `TBPU_ASSERT_IMP(a_no_pop_mid, i_clk, i_rst_n, (r_state == BK_MAP) || (r_state == BK_TILE), !o_pop, "pop mid lookup")

endmodule

/* sv/tile_background_pixel_unit_top.sv */
// Top level of the tile background pixel unit: config registers, front end, queue, back end.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  item in   | start / busy       | i_func, i_write_data, i_pixel_x, i_pixel_y
//  result    | o_strobe (1 cycle) | o_red, o_green, o_blue
//  config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  Video and palette writes are done as the back end takes them from the queue; set address
//  and unused codes stay in the front end. A pixel item goes through the tilemap read, the
//  bitplane read and the palette read, bound by the chain of synchronous reads on the video
//  and palette memories; the back end takes no new item until the palette read is back.
//  With an empty queue and an idle back end a pixel item passes the queue and those reads,
//  and then the result strobe is registered. After reset busy stays high while both memories
//  are cleared one word a cycle; config writes are taken during that time.
//  busy rises when the command queue is full; results cannot be held off.
module tile_background_pixel_unit_top #(
    parameter int VIDEO_BYTES   = tbpu_pkg::DEF_VIDEO_BYTES,
    parameter int PALETTE_BYTES = tbpu_pkg::DEF_PALETTE_BYTES,
    parameter int MAP_TILES     = tbpu_pkg::DEF_MAP_TILES,
    parameter int QUEUE_DEPTH   = tbpu_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_func,
    input  logic [15:0]                   i_write_data,
    input  logic [7:0]                    i_pixel_x,
    input  logic [7:0]                    i_pixel_y,
    output logic                          o_strobe,
    output logic [4:0]                    o_red,
    output logic [4:0]                    o_green,
    output logic [4:0]                    o_blue,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tbpu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbpu_pkg::*;

    logic [7:0]   r_map_base;
    logic         r_step_high;
    t_back_status back_status;
    t_cmd         push_cmd, head_cmd;
    logic         push, pop, q_valid, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_base  <= '0;
            r_step_high <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAP_BASE:  r_map_base  <= i_cfg_data[7:0];
                CFG_STEP_HIGH: r_step_high <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tbpu_front #(
        .PALETTE_BYTES(PALETTE_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_func           (i_func),
        .i_write_data     (i_write_data),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_step_after_high(r_step_high),
        .i_status         (back_status),
        .i_queue_full     (q_full),
        .o_busy           (busy),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    tbpu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (head_cmd)
    );

    tbpu_back #(
        .VIDEO_BYTES  (VIDEO_BYTES),
        .PALETTE_BYTES(PALETTE_BYTES),
        .MAP_TILES    (MAP_TILES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .i_map_base(r_map_base),
        .o_pop     (pop),
        .o_status  (back_status),
        .o_strobe  (o_strobe),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

endmodule

/* tb/tile_background_pixel_unit_checker.sv */
// Checker for the tile background pixel unit: tracks its memories, predicts and compares colours.
module tile_background_pixel_unit_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [2:0]                        i_func,
    input  logic [15:0]                       i_write_data,
    input  logic [7:0]                        i_pixel_x,
    input  logic [7:0]                        i_pixel_y,
    input  logic                              o_strobe,
    input  logic [4:0]                        o_red,
    input  logic [4:0]                        o_green,
    input  logic [4:0]                        o_blue,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [tbpu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tbpu_pkg::*;

    localparam int VB = DEF_VIDEO_BYTES;
    localparam int PB = DEF_PALETTE_BYTES;
    localparam int MT = DEF_MAP_TILES;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_colour;

    logic [7:0]  vram [VB];
    logic [7:0]  pram [PB];
    logic [15:0] word_addr;
    logic [8:0]  pal_addr;
    logic [7:0]  map_base;
    logic        step_high;
    t_colour     expected_colours [$];
    int          mismatches = 0;

    task automatic flag(string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned vbyte(int unsigned a);
        return vram[a % VB];
    endfunction

    function automatic int unsigned pbyte(int unsigned a);
        return pram[a % PB];
    endfunction

    function automatic t_colour predict_colour(logic [7:0] x, logic [7:0] y);
        int unsigned map_addr;
        int unsigned entry;
        int unsigned tile_addr;
        int unsigned sh;
        int unsigned idx;
        int unsigned col_addr;
        int unsigned c;
        t_colour     res;
        // tilemap base is in 2 KiB units; cell coordinates wrap on the map size
        map_addr = (32'(map_base[7:2]) << 11)
                 + 2 * ((32'(y[7:3]) % MT) * MT + (32'(x[7:3]) % MT));
        entry = vbyte(map_addr) | (vbyte(map_addr + 1) << 8);
        tile_addr = (entry & 32'h3FF) * 32 + 2 * 32'(y[2:0]);
        sh = 7 - 32'(x[2:0]);
        // planes 0/1 interleaved per row, planes 2/3 sixteen bytes on
        idx = ((vbyte(tile_addr) >> sh) & 1)
            | (((vbyte(tile_addr + 1) >> sh) & 1) << 1)
            | (((vbyte(tile_addr + 16) >> sh) & 1) << 2)
            | (((vbyte(tile_addr + 17) >> sh) & 1) << 3);
        col_addr = (((entry >> 10) & 32'h7) * 16 + idx) * 2;
        c = (pbyte(col_addr) | (pbyte(col_addr + 1) << 8)) & 32'h7FFF;
        res.red   = c[4:0];
        res.green = c[9:5];
        res.blue  = c[14:10];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_colour     got;
        t_colour     want;
        int unsigned byte_addr;
        if (!i_rst_n) begin
            for (int i = 0; i < VB; i++) vram[i] = '0;
            for (int i = 0; i < PB; i++) pram[i] = '0;
            word_addr = '0;
            pal_addr  = '0;
            map_base  = '0;
            step_high = 1'b0;
            expected_colours.delete();
        end else begin
            if (o_strobe) begin
                got = {o_red, o_green, o_blue};
                if (expected_colours.size() == 0) begin
                    flag($sformatf("pixel result %0d/%0d/%0d with none expected",
                                   o_red, o_green, o_blue));
                end else begin
                    want = expected_colours.pop_front();
                    if (got.red !== want.red)
                        flag($sformatf("red %0d, expected %0d", got.red, want.red));
                    if (got.green !== want.green)
                        flag($sformatf("green %0d, expected %0d", got.green, want.green));
                    if (got.blue !== want.blue)
                        flag($sformatf("blue %0d, expected %0d", got.blue, want.blue));
                end
            end

            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAP_BASE)
                    map_base = i_cfg_data[7:0];
                else
                    step_high = i_cfg_data[0];
            end

            if (start && !busy) begin
                byte_addr = 32'(word_addr) * 2;
                case (i_func)
                    FN_SET_ADDR: word_addr = i_write_data;
                    FN_WORD: begin
                        vram[byte_addr % VB]       = i_write_data[7:0];
                        vram[(byte_addr + 1) % VB] = i_write_data[15:8];
                        word_addr = word_addr + 16'd1;
                    end
                    FN_LOW: begin
                        vram[byte_addr % VB] = i_write_data[7:0];
                        if (!step_high) word_addr = word_addr + 16'd1;
                    end
                    FN_HIGH: begin
                        vram[(byte_addr + 1) % VB] = i_write_data[7:0];
                        if (step_high) word_addr = word_addr + 16'd1;
                    end
                    FN_PAL: begin
                        pram[pal_addr] = i_write_data[7:0];
                        pal_addr = 9'((32'(pal_addr) + 1) % PB);
                    end
                    FN_PIXEL: expected_colours.push_back(predict_colour(i_pixel_x, i_pixel_y));
                    default: ;
                endcase
            end
        end
        o_outstanding <= expected_colours.size();
        o_mismatches  <= mismatches;
    end

endmodule

/* tb/tb_tile_background_pixel_unit_top.sv */
// Testbench top for the tile background pixel unit: drives items and config, gives the verdict.
module tb_tile_background_pixel_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbpu_pkg::*;

    // codes the block ignores
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;
    localparam int DRAIN_CYCLES    = 24;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 350;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [2:0]              i_func;
    logic [15:0]             i_write_data;
    logic [7:0]              i_pixel_x;
    logic [7:0]              i_pixel_y;
    logic                    o_strobe;
    logic [4:0]              o_red;
    logic [4:0]              o_green;
    logic [4:0]              o_blue;
    logic                    i_cfg_we;
    logic                    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    int                      mismatches;
    int                      outstanding;

    int         idle_pct   = 0;
    int         items_sent = 0;
    logic [7:0] cur_base;
    logic       cur_step;

    tile_background_pixel_unit_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_write_data (i_write_data),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_strobe     (o_strobe),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tile_background_pixel_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_write_data  (i_write_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_strobe      (o_strobe),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Holds the item until the edge that takes it, then maybe leaves a gap.
    task automatic send_item(logic [2:0] f, logic [15:0] d, logic [7:0] x, logic [7:0] y);
        start        <= 1'b1;
        i_func       <= f;
        i_write_data <= d;
        i_pixel_x    <= x;
        i_pixel_y    <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (f <= FN_PIXEL) items_sent++;
        if ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // Waits until every pixel result is back and queued writes have retired.
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] base, logic step);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAP_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_STEP_HIGH;
        i_cfg_data  <= CFG_DATA_W'(step);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_base = base;
        cur_step = step;
    endtask

    // Low and high byte in the order that steps the address once per word.
    task automatic put_pair(logic [15:0] value);
        if (cur_step) begin
            send_item(FN_LOW, {8'($urandom), value[7:0]}, 8'($urandom), 8'($urandom));
            send_item(FN_HIGH, {8'($urandom), value[15:8]}, 8'($urandom), 8'($urandom));
        end else begin
            send_item(FN_HIGH, {8'($urandom), value[15:8]}, 8'($urandom), 8'($urandom));
            send_item(FN_LOW, {8'($urandom), value[7:0]}, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic put_word(logic [15:0] addr, logic [15:0] value);
        send_item(FN_SET_ADDR, addr, 8'($urandom), 8'($urandom));
        case ($urandom_range(2, 0))
            0: send_item(FN_WORD, value, 8'($urandom), 8'($urandom));
            1: put_pair(value);
            default: begin
                send_item(FN_LOW, {8'($urandom), value[7:0]}, 8'($urandom), 8'($urandom));
                send_item(FN_SET_ADDR, addr, 8'($urandom), 8'($urandom));
                send_item(FN_HIGH, {8'($urandom), value[15:8]}, 8'($urandom), 8'($urandom));
            end
        endcase
    endtask

    // Writes the map entry and one tile row under a random pixel, then reads along that row.
    task automatic paint_and_probe();
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] entry;
        logic [15:0] row_word;
        x = 8'($urandom);
        y = 8'($urandom);
        entry = 16'($urandom);
        row_word = {entry[9:0], 4'd0} + 16'(y[2:0]);
        put_word({cur_base[7:2], y[7:3], x[7:3]}, entry);
        put_word(row_word, 16'($urandom));
        put_word(row_word + 16'd8, 16'($urandom));
        repeat ($urandom_range(4, 1))
            send_item(FN_PIXEL, 16'($urandom), {x[7:3], 3'($urandom)}, y);
    endtask

    task automatic run_phase(int goal, int pct);
        int stop_at;
        int pick;
        idle_pct = pct;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                paint_and_probe();
            end else if (pick < 65) begin
                repeat ($urandom_range(64, 1))
                    send_item(FN_PAL, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 78) begin
                repeat ($urandom_range(4, 1))
                    send_item(FN_PIXEL, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 88) begin
                // run of words from a random address, often near the top to see the wrap
                send_item(FN_SET_ADDR,
                          ($urandom_range(3, 0) == 0) ? {12'hFFF, 4'($urandom)} : 16'($urandom),
                          8'($urandom), 8'($urandom));
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(1, 0))
                        send_item(FN_WORD, 16'($urandom), 8'($urandom), 8'($urandom));
                    else
                        put_pair(16'($urandom));
                end
            end else if (pick < 98) begin
                repeat ($urandom_range(4, 1))
                    send_item(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FN_SET_ADDR;
        i_write_data <= '0;
        i_pixel_x    <= '0;
        i_pixel_y    <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_MAP_BASE;
        i_cfg_data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // map at 2 KiB; the low two base bits are don't-care
        set_config(8'h07, 1'b0);
        send_item(FN_PIXEL, 16'h0000, 8'd0, 8'd0);
        send_item(FN_SPARE_A, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(FN_SPARE_B, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(FN_PAL, 16'hFFFF, 8'd0, 8'd0);
        send_item(FN_PAL, 16'h00FF, 8'd0, 8'd0);  // colour bit 15 set, must be dropped
        send_item(FN_SET_ADDR, 16'd2047, 8'd0, 8'd0);  // bottom-right cell entry
        send_item(FN_WORD, 16'hE3FF, 8'd0, 8'd0);  // tile 1023, palette 0, flag bits set
        send_item(FN_PIXEL, 16'h0000, 8'hFF, 8'hFF);
        send_item(FN_SET_ADDR, 16'hFFFF, 8'd0, 8'd0);
        send_item(FN_WORD, 16'hFFFF, 8'd0, 8'd0);  // byte address wraps, word address wraps to 0
        send_item(FN_WORD, 16'h8001, 8'd0, 8'd0);
        send_item(FN_PIXEL, 16'h0000, 8'hF8, 8'hFF);
        send_item(FN_SET_ADDR, 16'd16375, 8'd0, 8'd0);
        send_item(FN_LOW, 16'hFF80, 8'd0, 8'd0);
        send_item(FN_SET_ADDR, 16'd16375, 8'd0, 8'd0);
        send_item(FN_HIGH, 16'h0001, 8'd0, 8'd0);
        send_item(FN_HIGH, 16'h00FF, 8'd0, 8'd0);  // no step after high in this mode
        send_item(FN_PIXEL, 16'hFFFF, 8'hF8, 8'hFF);
        send_item(FN_PIXEL, 16'h0000, 8'hFF, 8'hFF);
        send_item(FN_PIXEL, 16'h0000, 8'd128, 8'd77);
        drain();

        set_config(8'hFF, 1'b1);
        run_phase(ITEMS_PER_PHASE, 0);
        drain();
        set_config(8'h00, 1'b0);
        run_phase(ITEMS_PER_PHASE, 60);
        drain();
        set_config(8'($urandom), 1'($urandom));
        run_phase(ITEMS_PER_PHASE, 0);
        drain();
        set_config(8'($urandom), 1'($urandom));
        run_phase(ITEMS_PER_PHASE, 33);
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            if (outstanding != 0) $display("%0d pixel results never came", outstanding);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
